[hw/rtl/rcs_pkg.sv]
// Shared types, codes and helper functions for the rotor cipher stepper.
`timescale 1ns / 1ps

package rcs_pkg;

    // Alphabet and letter coding.
    localparam int ALPHA_SIZE = 26;
    localparam int LETTER_W   = 5;
    localparam int DEF_ROTOR_COUNT = 3;

    typedef logic [LETTER_W-1:0] letter_t;

    // Operation codes carried in the op field.
    localparam logic OP_LOAD     = 1'b0;
    localparam logic OP_ENCIPHER = 1'b1;

    // Table select codes for load transactions.
    localparam logic [2:0] TS_PLUG    = 3'd0;
    localparam logic [2:0] TS_REFLECT = 3'd1;
    localparam logic [2:0] TS_ROTOR0  = 3'd2;

    // ASCII anchors for letter detection.
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_UPPER_Z = 8'h5A;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_LOWER_Z = 8'h7A;

    // Input transaction payload.
    typedef struct packed {
        logic       op;
        logic [2:0] table_select;
        logic [4:0] entry_index;
        logic [4:0] entry_value;
        logic [7:0] in_char;
    } in_item_t;

    // Result transaction payload.
    typedef struct packed {
        logic [7:0] out_char;
        logic       not_letter;
    } out_item_t;

    // Write command for one wiring table.
    typedef struct packed {
        logic    en;
        letter_t idx;
        letter_t val;
    } wr_cmd_t;

    // (a - k) mod 26 for a, k below 26.
    function automatic letter_t wrap_sub(input letter_t a, input letter_t k);
        logic [LETTER_W:0] t;
        begin
            if (a >= k) begin
                t = {1'b0, a} - {1'b0, k};
            end else begin
                t = {1'b0, a} + (LETTER_W+1)'(ALPHA_SIZE) - {1'b0, k};
            end
            return t[LETTER_W-1:0];
        end
    endfunction

    // (a + k) mod 26 for a, k below 26.
    function automatic letter_t wrap_add(input letter_t a, input letter_t k);
        logic [LETTER_W:0] t;
        begin
            t = {1'b0, a} + {1'b0, k};
            if (t >= (LETTER_W+1)'(ALPHA_SIZE)) begin
                t = t - (LETTER_W+1)'(ALPHA_SIZE);
            end
            return t[LETTER_W-1:0];
        end
    endfunction

endpackage

[hw/rtl/rotor_cipher_stepper_core.sv]
// Top level of the rotor cipher stepper: input register, cipher path, result register.
`timescale 1ns / 1ps

// Channel | Direction | Payload    | Handshake
// s_      | input     | in_item_t  | s_valid / s_ready
// m_      | output    | out_item_t | m_valid / m_ready
//
// An accepted transaction is held in the input register, then passes the whole
// plugboard, rotor and reflector chain combinationally into the result register.
// Throughput is one transaction per cycle unless a stalled result holds an encipher.
// Loads write their table as they leave the input register and produce no result.
// Reset clears the valid flags and the rotor offsets; wiring tables are not cleared.
// A stalled result only holds back encipher transactions; loads still drain.

module rotor_cipher_stepper_core
    import rcs_pkg::*;
#(
    parameter int ROTOR_COUNT = DEF_ROTOR_COUNT
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  in_item_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output out_item_t m_data
);

    in_item_t  in_reg;
    logic      in_valid_reg, in_valid_next;
    out_item_t m_data_reg, m_data_next;
    logic      m_valid_reg, m_valid_next;
    letter_t   offset_reg [ROTOR_COUNT];
    letter_t   offset_next [ROTOR_COUNT];

    logic      fire;
    logic      is_enc;
    logic      is_lower, is_upper, is_letter;
    letter_t   code;
    logic      load_ok;
    logic      step_en;
    logic      carry;
    wr_cmd_t   plug_wr, refl_wr;
    wr_cmd_t   rotor_wr [ROTOR_COUNT];
    letter_t   plug_in_out, refl_out, plug_out_out;
    letter_t   fwd_chain [ROTOR_COUNT+1];
    letter_t   bwd_chain [ROTOR_COUNT+1];

    // Handshake: the held transaction leaves when it is a load or the result slot frees.
    assign is_enc  = (in_reg.op == OP_ENCIPHER);
    assign fire    = in_valid_reg && (!is_enc || !m_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || fire;
    assign in_valid_next = s_ready ? s_valid : in_valid_reg;

    // Input register.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg <= 1'b0;
        end else begin
            in_valid_reg <= in_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (s_valid && s_ready) begin
            in_reg <= s_data;
        end
    end

    // Letter detection and case folding.
    always_comb begin
        is_lower  = in_reg.in_char inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
        is_upper  = in_reg.in_char inside {[CHAR_UPPER_A:CHAR_UPPER_Z]};
        is_letter = is_lower || is_upper;
        if (is_lower) begin
            code = LETTER_W'(in_reg.in_char - CHAR_LOWER_A);
        end else begin
            code = LETTER_W'(in_reg.in_char - CHAR_UPPER_A);
        end
    end

    // Table write commands for a load transaction with in-range index and value.
    assign load_ok = fire && (in_reg.op == OP_LOAD)
                     && (in_reg.entry_index < LETTER_W'(ALPHA_SIZE))
                     && (in_reg.entry_value < LETTER_W'(ALPHA_SIZE));

    always_comb begin
        plug_wr.en  = load_ok && (in_reg.table_select == TS_PLUG);
        plug_wr.idx = in_reg.entry_index;
        plug_wr.val = in_reg.entry_value;
        refl_wr.en  = load_ok && (in_reg.table_select == TS_REFLECT);
        refl_wr.idx = in_reg.entry_index;
        refl_wr.val = in_reg.entry_value;
    end

    // Plugboard on the way in; a second copy serves the way out.
    rcs_map u_plug_in (
        .aclk    (aclk),
        .wr      (plug_wr),
        .rd_addr (code),
        .rd_data (plug_in_out)
    );

    assign fwd_chain[0] = plug_in_out;

    // Rotors: forward pass low to high, backward pass high to low.
    for (genvar r = 0; r < ROTOR_COUNT; r++) begin : g_rotor
        always_comb begin
            rotor_wr[r].en  = load_ok && (in_reg.table_select == 3'(TS_ROTOR0 + r));
            rotor_wr[r].idx = in_reg.entry_index;
            rotor_wr[r].val = in_reg.entry_value;
        end

        rcs_rotor u_rotor (
            .aclk    (aclk),
            .wr      (rotor_wr[r]),
            .offset  (offset_reg[r]),
            .fwd_in  (fwd_chain[r]),
            .fwd_out (fwd_chain[r+1]),
            .bwd_in  (bwd_chain[r+1]),
            .bwd_out (bwd_chain[r])
        );
    end

    // Reflector.
    rcs_map u_reflect (
        .aclk    (aclk),
        .wr      (refl_wr),
        .rd_addr (fwd_chain[ROTOR_COUNT]),
        .rd_data (refl_out)
    );

    assign bwd_chain[ROTOR_COUNT] = refl_out;

    rcs_map u_plug_out (
        .aclk    (aclk),
        .wr      (plug_wr),
        .rd_addr (bwd_chain[0]),
        .rd_data (plug_out_out)
    );

    // Odometer stepping after each enciphered letter.
    assign step_en = fire && is_enc && is_letter;

    always_comb begin
        carry = step_en;
        for (int r = 0; r < ROTOR_COUNT; r++) begin
            offset_next[r] = offset_reg[r];
            if (carry) begin
                if (offset_reg[r] == letter_t'(ALPHA_SIZE - 1)) begin
                    offset_next[r] = '0;
                end else begin
                    offset_next[r] = offset_reg[r] + letter_t'(1);
                    carry = 1'b0;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int r = 0; r < ROTOR_COUNT; r++) begin
                offset_reg[r] <= '0;
            end
        end else begin
            for (int r = 0; r < ROTOR_COUNT; r++) begin
                offset_reg[r] <= offset_next[r];
            end
        end
    end

    // Result register.
    always_comb begin
        m_data_next  = m_data_reg;
        m_valid_next = m_valid_reg && !m_ready;
        if (fire && is_enc) begin
            m_valid_next = 1'b1;
            if (is_letter) begin
                m_data_next.out_char   = CHAR_UPPER_A + {3'b000, plug_out_out};
                m_data_next.not_letter = 1'b0;
            end else begin
                m_data_next.out_char   = in_reg.in_char;
                m_data_next.not_letter = 1'b1;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        m_data_reg <= m_data_next;
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // The first rotor offset always stays inside the alphabet.
    a_offset_range: assert property (@(posedge aclk) disable iff (!aresetn)
        offset_reg[0] < letter_t'(ALPHA_SIZE))
        else $error("rotor 0 offset out of range");

    // Offsets move only when a letter is enciphered.
    a_offset_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        !step_en |=> $stable(offset_reg[0]))
        else $error("rotor offset changed without an enciphered letter");

    // A load transaction never produces a result.
    a_load_no_result: assert property (@(posedge aclk) disable iff (!aresetn)
        (fire && !is_enc && !m_valid_reg) |=> !m_valid_reg)
        else $error("load transaction produced a result");

    // Back pressure on the input only comes from a held transaction.
    a_ready_cause: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_ready |-> (in_valid_reg && is_enc && m_valid_reg && !m_ready))
        else $error("input stalled without cause");

endmodule

[hw/rtl/rcs_map.sv]
// One 26-entry wiring table with a single write port and a single lookup port.
`timescale 1ns / 1ps

module rcs_map
    import rcs_pkg::*;
(
    input  logic    aclk,
    input  wr_cmd_t wr,
    input  letter_t rd_addr,
    output letter_t rd_data
);

    letter_t map_reg [ALPHA_SIZE];

    // Table write; contents are undefined until loaded.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            map_reg[wr.idx] <= wr.val;
        end
    end

    // Lookup.
    assign rd_data = map_reg[rd_addr];

endmodule

[hw/rtl/rcs_rotor.sv]
// One rotor: forward and inverse wiring tables with offset-adjusted lookups.
`timescale 1ns / 1ps

module rcs_rotor
    import rcs_pkg::*;
(
    input  logic    aclk,
    input  wr_cmd_t wr,
    input  letter_t offset,
    input  letter_t fwd_in,
    output letter_t fwd_out,
    input  letter_t bwd_in,
    output letter_t bwd_out
);

    letter_t fwd_reg [ALPHA_SIZE];
    letter_t inv_reg [ALPHA_SIZE];
    letter_t wr_base;

    // A load addresses the rotor as it currently stands.
    assign wr_base = wrap_sub(wr.idx, offset);

    // Forward and inverse tables are written together.
    always_ff @(posedge aclk) begin
        if (wr.en) begin
            fwd_reg[wr_base] <= wr.val;
            inv_reg[wr.val]  <= wr_base;
        end
    end

    // Forward and backward passes through the rotated wiring.
    assign fwd_out = fwd_reg[wrap_sub(fwd_in, offset)];
    assign bwd_out = wrap_add(inv_reg[bwd_in], offset);

endmodule

[dv/tb_rotor_cipher_stepper_core.sv]
// Self-checking testbench for the rotor cipher stepper core with directed and random traffic.
`timescale 1ns / 1ps

module tb_rotor_cipher_stepper_core;
    import rcs_pkg::*;

    localparam int ROTORS       = DEF_ROTOR_COUNT;
    localparam int RANDOM_ITEMS = 1100;
    localparam int STALL_LIMIT  = 2000;
    localparam int HOLD_CYCLES  = 200;
    localparam int HOLD_SPACING = 500;
    localparam int MAX_REPORTS  = 10;
    localparam int DRAIN_CYCLES = 8;
    // Table select codes past the last rotor address nothing.
    localparam int TS_NONE_FIRST = int'(TS_ROTOR0) + ROTORS;
    localparam int SEL_MAX       = 7;

    logic      aclk    = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    in_item_t  s_data  = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    out_item_t m_data;

    rotor_cipher_stepper_core u_top (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    // Predicted wiring tables and rotor positions.
    letter_t plug_wiring       [ALPHA_SIZE];
    letter_t reflect_wiring    [ALPHA_SIZE];
    letter_t rotor_fwd_wiring  [ROTORS][ALPHA_SIZE];
    letter_t rotor_back_wiring [ROTORS][ALPHA_SIZE];
    letter_t rotor_pos         [ROTORS];

    in_item_t  pending_items[$];
    out_item_t expected_chars[$];
    out_item_t want;
    int        mismatch_count = 0;
    int        accepted_in    = 0;
    int        total_items    = 0;
    int        idle_cycles    = 0;
    logic      in_taken       = 1'b0;

    int tx_gap       = 0;
    int tx_calm      = 0;
    int rx_stall     = 0;
    int rx_calm      = 0;
    int hold_left    = 0;
    int next_hold_at = 300;

    initial begin
        forever #5 aclk = ~aclk;
    end

    function automatic bit is_letter(input logic [7:0] ch);
        return (ch >= CHAR_UPPER_A && ch <= CHAR_UPPER_Z) ||
               (ch >= CHAR_LOWER_A && ch <= CHAR_LOWER_Z);
    endfunction

    function automatic int sub26(input int a, input int k);
        return (a + ALPHA_SIZE - k) % ALPHA_SIZE;
    endfunction

    // Idle length: mostly none or short, now and then long.
    function automatic int rand_idle();
        int r;
        r = $urandom_range(0, 99);
        if (r < 60) return 0;
        if (r < 90) return $urandom_range(1, 3);
        if (r < 98) return $urandom_range(4, 12);
        return $urandom_range(20, 60);
    endfunction

    function automatic in_item_t load_item(input int sel, input int idx, input int val);
        in_item_t item;
        item.op           = OP_LOAD;
        item.table_select = 3'(sel);
        item.entry_index  = 5'(idx);
        item.entry_value  = 5'(val);
        item.in_char      = 8'($urandom_range(0, 255));
        return item;
    endfunction

    // Unused load fields carry random bits on encipher transactions.
    function automatic in_item_t char_item(input int ch);
        in_item_t item;
        item.op           = OP_ENCIPHER;
        item.table_select = 3'($urandom_range(0, SEL_MAX));
        item.entry_index  = 5'($urandom_range(0, 31));
        item.entry_value  = 5'($urandom_range(0, 31));
        item.in_char      = 8'(ch);
        return item;
    endfunction

    // Queue a full rewrite of one table with a freshly shuffled permutation.
    task automatic queue_wiring(input int sel);
        int perm[ALPHA_SIZE];
        int j;
        int t;
        foreach (perm[i]) perm[i] = i;
        for (int i = ALPHA_SIZE - 1; i > 0; i--) begin
            j       = $urandom_range(0, i);
            t       = perm[i];
            perm[i] = perm[j];
            perm[j] = t;
        end
        foreach (perm[i]) pending_items.push_back(load_item(sel, i, perm[i]));
    endtask

    // Update the predicted wiring for a load, or queue the expected cipher output.
    task automatic apply_cipher_item(input in_item_t item);
        int        sel;
        int        idx;
        int        val;
        int        r;
        int        x;
        int        base;
        bit        carry;
        out_item_t res;
        sel = int'(item.table_select);
        idx = int'(item.entry_index);
        val = int'(item.entry_value);
        if (item.op == OP_LOAD) begin
            // Out-of-range positions or values and unknown tables change nothing.
            if (idx < ALPHA_SIZE && val < ALPHA_SIZE) begin
                if (item.table_select == TS_PLUG) begin
                    plug_wiring[idx] = letter_t'(val);
                end else if (item.table_select == TS_REFLECT) begin
                    reflect_wiring[idx] = letter_t'(val);
                end else if (sel - int'(TS_ROTOR0) < ROTORS) begin
                    // The load addresses the rotor as it currently stands.
                    r    = sel - int'(TS_ROTOR0);
                    base = sub26(idx, int'(rotor_pos[r]));
                    rotor_fwd_wiring[r][base] = letter_t'(val);
                    rotor_back_wiring[r][val] = letter_t'(base);
                end
            end
        end else if (!is_letter(item.in_char)) begin
            res.out_char   = item.in_char;
            res.not_letter = 1'b1;
            expected_chars.push_back(res);
        end else begin
            if (item.in_char >= CHAR_LOWER_A) begin
                x = int'(item.in_char) - int'(CHAR_LOWER_A);
            end else begin
                x = int'(item.in_char) - int'(CHAR_UPPER_A);
            end
            x = int'(plug_wiring[x]);
            for (r = 0; r < ROTORS; r++) begin
                x = int'(rotor_fwd_wiring[r][sub26(x, int'(rotor_pos[r]))]);
            end
            x = int'(reflect_wiring[x]);
            for (r = ROTORS - 1; r >= 0; r--) begin
                x = (int'(rotor_back_wiring[r][x]) + int'(rotor_pos[r])) % ALPHA_SIZE;
            end
            x = int'(plug_wiring[x]);
            res.out_char   = CHAR_UPPER_A + 8'(x);
            res.not_letter = 1'b0;
            expected_chars.push_back(res);
            // Odometer stepping: a wrap to zero carries into the next rotor.
            carry = 1'b1;
            for (r = 0; r < ROTORS; r++) begin
                if (carry) begin
                    if (rotor_pos[r] == letter_t'(ALPHA_SIZE - 1)) begin
                        rotor_pos[r] = '0;
                    end else begin
                        rotor_pos[r] = rotor_pos[r] + letter_t'(1);
                        carry        = 1'b0;
                    end
                end
            end
        end
    endtask

    // Sender: offers queued transactions and holds each one until it is taken.
    always @(negedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
        end else if (s_valid && !in_taken) begin
            // The offered transaction is still waiting; keep it steady.
        end else if (tx_gap > 0) begin
            s_valid <= 1'b0;
            tx_gap  <= tx_gap - 1;
        end else if (pending_items.size() > 0) begin
            s_valid <= 1'b1;
            s_data  <= pending_items.pop_front();
            tx_gap  <= (tx_calm > 0 || hold_left > 0) ? 0 : rand_idle();
            tx_calm <= (tx_calm > 0) ? tx_calm - 1 : (($urandom_range(0, 29) == 0) ? 50 : 0);
        end else begin
            s_valid <= 1'b0;
        end
    end

    // Receiver: random back-pressure plus a periodic long hold-off.
    always @(negedge aclk) begin
        if (!aresetn) begin
            m_ready <= 1'b0;
        end else if (hold_left > 0) begin
            m_ready   <= 1'b0;
            hold_left <= hold_left - 1;
        end else if (accepted_in >= next_hold_at) begin
            // The core fills up during this stretch and must stall its input.
            m_ready      <= 1'b0;
            hold_left    <= HOLD_CYCLES;
            next_hold_at <= next_hold_at + HOLD_SPACING;
        end else if (rx_stall > 0) begin
            m_ready  <= 1'b0;
            rx_stall <= rx_stall - 1;
        end else begin
            m_ready  <= 1'b1;
            rx_stall <= (rx_calm > 0) ? 0 : rand_idle();
            rx_calm  <= (rx_calm > 0) ? rx_calm - 1 : (($urandom_range(0, 29) == 0) ? 50 : 0);
        end
    end

    // Monitor: checks results against predictions, tracks inputs, runs the watchdog.
    always @(posedge aclk) begin
        in_taken <= aresetn && s_valid && s_ready;
        if (aresetn) begin
            if (m_valid && m_ready) begin
                if (expected_chars.size() == 0) begin
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTS) begin
                        $display("Unexpected result transaction: out_char=%h not_letter=%b",
                                 m_data.out_char, m_data.not_letter);
                    end
                end else begin
                    want = expected_chars.pop_front();
                    if (m_data.out_char !== want.out_char ||
                        m_data.not_letter !== want.not_letter) begin
                        mismatch_count++;
                        if (mismatch_count <= MAX_REPORTS) begin
                            $display("Result mismatch: expected out_char=%h not_letter=%b, %s",
                                     want.out_char, want.not_letter,
                                     $sformatf("got out_char=%h not_letter=%b",
                                               m_data.out_char, m_data.not_letter));
                        end
                    end
                end
            end
            if (s_valid && s_ready) begin
                apply_cipher_item(s_data);
                accepted_in++;
            end
            if ((s_valid && s_ready) || (m_valid && m_ready) ||
                (pending_items.size() == 0 && !s_valid && expected_chars.size() == 0)) begin
                idle_cycles = 0;
            end else begin
                idle_cycles++;
            end
            if (idle_cycles >= STALL_LIMIT) begin
                $display("SCOREBOARD MISMATCH");
                $finish;
            end
        end
    end

    // Stimulus, reset and end of test.
    initial begin
        int ch;
        int r;
        int kind;
        int sel;
        int limit;

        foreach (rotor_pos[i]) rotor_pos[i] = '0;

        // Non-letters around the letter ranges pass before any table is loaded.
        pending_items.push_back(char_item(8'h00));
        pending_items.push_back(char_item(8'hFF));
        pending_items.push_back(char_item(int'(CHAR_UPPER_A) - 1));
        pending_items.push_back(char_item(int'(CHAR_UPPER_Z) + 1));
        pending_items.push_back(char_item(int'(CHAR_LOWER_A) - 1));
        pending_items.push_back(char_item(int'(CHAR_LOWER_Z) + 1));
        pending_items.push_back(char_item(8'h80));

        // Loads with out-of-range position or value, or an unknown table, are dropped.
        pending_items.push_back(load_item(TS_PLUG, ALPHA_SIZE, 0));
        pending_items.push_back(load_item(TS_REFLECT, 31, 5));
        pending_items.push_back(load_item(TS_ROTOR0, 3, ALPHA_SIZE));
        pending_items.push_back(load_item(int'(TS_ROTOR0) + ROTORS - 1, 0, 31));
        pending_items.push_back(load_item(TS_NONE_FIRST, 1, 1));
        pending_items.push_back(load_item(TS_NONE_FIRST + 1, ALPHA_SIZE - 1, ALPHA_SIZE - 1));
        pending_items.push_back(load_item(SEL_MAX, 31, 31));

        // Every table is fully written before the first letter goes through.
        queue_wiring(TS_PLUG);
        queue_wiring(TS_REFLECT);
        for (r = 0; r < ROTORS; r++) queue_wiring(int'(TS_ROTOR0) + r);

        // Letter extremes in both cases.
        pending_items.push_back(char_item(CHAR_UPPER_A));
        pending_items.push_back(char_item(CHAR_UPPER_Z));
        pending_items.push_back(char_item(CHAR_LOWER_A));
        pending_items.push_back(char_item(CHAR_LOWER_Z));
        pending_items.push_back(char_item(int'(CHAR_UPPER_A) + 13));

        // Random traffic: mostly letters, with rewiring mid-stream and some dropped loads.
        limit = pending_items.size() + RANDOM_ITEMS;
        while (pending_items.size() < limit) begin
            r = $urandom_range(0, 99);
            if (r < 3) begin
                queue_wiring($urandom_range(0, TS_NONE_FIRST - 1));
            end else if (r < 68) begin
                ch = ($urandom_range(0, 1) ? int'(CHAR_UPPER_A) : int'(CHAR_LOWER_A)) +
                     $urandom_range(0, ALPHA_SIZE - 1);
                pending_items.push_back(char_item(ch));
            end else if (r < 78) begin
                do begin
                    ch = $urandom_range(0, 255);
                end while (is_letter(8'(ch)));
                pending_items.push_back(char_item(ch));
            end else if (r < 93) begin
                pending_items.push_back(load_item($urandom_range(0, TS_NONE_FIRST - 1),
                                                  $urandom_range(0, ALPHA_SIZE - 1),
                                                  $urandom_range(0, ALPHA_SIZE - 1)));
            end else begin
                kind = $urandom_range(0, 2);
                sel  = $urandom_range(0, TS_NONE_FIRST - 1);
                if (kind == 0) begin
                    pending_items.push_back(load_item($urandom_range(TS_NONE_FIRST, SEL_MAX),
                                                      $urandom_range(0, 31),
                                                      $urandom_range(0, 31)));
                end else if (kind == 1) begin
                    pending_items.push_back(load_item(sel, $urandom_range(ALPHA_SIZE, 31),
                                                      $urandom_range(0, 31)));
                end else begin
                    pending_items.push_back(load_item(sel, $urandom_range(0, ALPHA_SIZE - 1),
                                                      $urandom_range(ALPHA_SIZE, 31)));
                end
            end
        end
        total_items = pending_items.size();

        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn <= 1'b1;

        wait (accepted_in == total_items);
        wait (expected_chars.size() == 0);
        repeat (DRAIN_CYCLES) @(posedge aclk);
        if (mismatch_count == 0 && expected_chars.size() == 0) begin
            $display("SCOREBOARD CLEAN");
        end else begin
            $display("SCOREBOARD MISMATCH");
        end
        $finish;
    end

endmodule
